// ----- rtl/base64_stream_encoder_core_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the base64 stream encoder
// Concurrent implication checks, clocked on the rising edge, off in reset.
// ---------------------------------------------------------------------------
`ifndef BASE64_STREAM_ENCODER_CORE_ASSERT_SVH
`define BASE64_STREAM_ENCODER_CORE_ASSERT_SVH

// same-cycle implication
`define B64E_ASSERT_IMPL(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("b64e assertion failed");

// next-cycle implication
`define B64E_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("b64e assertion failed");

`endif

// ----- rtl/b64e_pkg.sv -----
// ---------------------------------------------------------------------------
// b64e_pkg
// Shared types, character codes and the sextet-to-character map.
// ---------------------------------------------------------------------------
package b64e_pkg;

    localparam logic [6:0] CHAR_LOWER_A = 7'd97;
    localparam logic [6:0] CHAR_LOWER_Z = 7'd122;
    localparam logic [6:0] CHAR_UPPER_A = 7'd65;
    localparam logic [6:0] CHAR_UPPER_Z = 7'd90;
    localparam logic [6:0] CHAR_DIGIT_0 = 7'd48;
    localparam logic [6:0] CHAR_DIGIT_9 = 7'd57;
    localparam logic [6:0] CHAR_PLUS    = 7'd43;
    localparam logic [6:0] CHAR_SLASH   = 7'd47;
    localparam logic [6:0] PAD_CHAR     = 7'd61;

    typedef enum logic [1:0] {
        PAD_NONE,
        PAD_ONE,
        PAD_TWO
    } pad_t;

    typedef struct packed {
        logic [23:0] bits;
        pad_t        pad;
        logic        last;
    } group_t;

    function automatic logic [6:0] sextet_char(input logic [5:0] idx);
        logic [6:0] code;
        priority if (idx < 6'd26)
        begin
            code = CHAR_LOWER_A + {1'b0, idx};
        end
        else if (idx < 6'd52)
        begin
            code = CHAR_UPPER_A + {1'b0, idx - 6'd26};
        end
        else if (idx < 6'd62)
        begin
            code = CHAR_DIGIT_0 + {1'b0, idx - 6'd52};
        end
        else if (idx == 6'd62)
        begin
            code = CHAR_PLUS;
        end
        else
        begin
            code = CHAR_SLASH;
        end
        return code;
    endfunction

endpackage

// ----- rtl/b64e_stream_if.sv -----
// ---------------------------------------------------------------------------
// b64e stream interfaces
// Byte channel in, character channel out; valid/ready handshake.
// ---------------------------------------------------------------------------
interface b64e_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64e_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

// ----- rtl/b64e_queue.sv -----
// ---------------------------------------------------------------------------
// b64e_queue
// Small register queue of encoded groups between front and back.
// ---------------------------------------------------------------------------
module b64e_queue #(
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  b64e_pkg::group_t push_data,
    output logic             full,
    input  logic             pop,
    output b64e_pkg::group_t pop_data,
    output logic             empty
);
    import b64e_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    group_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/b64e_front.sv -----
// ---------------------------------------------------------------------------
// b64e_front
// Byte intake: hold up to two pending bytes, issue a group per triple
// or on the final byte of a message.
// ---------------------------------------------------------------------------
module b64e_front (
    input  logic             clk,
    input  logic             rst_n,
    b64e_byte_if.sink        byte_in,
    input  logic             queue_full,
    output logic             push,
    output b64e_pkg::group_t push_data
);
    import b64e_pkg::*;

    logic [15:0] pending_bytes_reg;
    logic [15:0] pending_bytes_next;
    logic [1:0]  pending_count_reg;
    logic [1:0]  pending_count_next;
    logic        accept;
    logic        complete;

    assign byte_in.ready = !queue_full;
    assign accept        = byte_in.valid && byte_in.ready;
    assign complete      = byte_in.end_of_message || pending_count_reg[1];
    assign push          = accept && complete;

    always_comb
    begin
        priority if (pending_count_reg[1])
        begin
            push_data.bits = {pending_bytes_reg, byte_in.data_byte};
            push_data.pad  = PAD_NONE;
            push_data.last = byte_in.end_of_message;
        end
        else if (pending_count_reg[0])
        begin
            push_data.bits = {pending_bytes_reg[15:8], byte_in.data_byte, 8'h00};
            push_data.pad  = PAD_ONE;
            push_data.last = 1'b1;
        end
        else
        begin
            push_data.bits = {byte_in.data_byte, 16'h0000};
            push_data.pad  = PAD_TWO;
            push_data.last = 1'b1;
        end
    end

    always_comb
    begin
        pending_bytes_next = pending_bytes_reg;
        pending_count_next = pending_count_reg;
        if (accept)
        begin
            priority if (complete)
            begin
                pending_bytes_next = '0;
                pending_count_next = '0;
            end
            else if (pending_count_reg == 2'd0)
            begin
                pending_bytes_next = {byte_in.data_byte, 8'h00};
                pending_count_next = 2'd1;
            end
            else
            begin
                pending_bytes_next = {pending_bytes_reg[15:8], byte_in.data_byte};
                pending_count_next = 2'd2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_bytes_reg <= '0;
            pending_count_reg <= '0;
        end
        else
        begin
            pending_bytes_reg <= pending_bytes_next;
            pending_count_reg <= pending_count_next;
        end
    end

endmodule

// ----- rtl/b64e_back.sv -----
// ---------------------------------------------------------------------------
// b64e_back
// Character emitter: step through the four characters of each group,
// one per cycle while the receiver is ready, into the output register.
// ---------------------------------------------------------------------------
module b64e_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             queue_empty,
    output logic             pop,
    input  b64e_pkg::group_t pop_data,
    b64e_char_if.source      char_out
);
    import b64e_pkg::*;

    group_t      entry_reg;
    group_t      entry_next;
    logic        have_entry_reg;
    logic        have_entry_next;
    logic [1:0]  pos_reg;
    logic [1:0]  pos_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [6:0]  out_char_reg;
    logic [6:0]  out_char_next;
    logic        out_last_reg;
    logic        out_last_next;
    logic        load;
    logic        final_pos;
    logic [5:0]  sextet;
    logic        is_pad;

    assign load      = have_entry_reg && (!out_valid_reg || char_out.ready);
    assign final_pos = (pos_reg == 2'd3);
    assign pop       = !queue_empty && (!have_entry_reg || (load && final_pos));

    always_comb
    begin
        unique case (pos_reg)
            2'd0: sextet = entry_reg.bits[23:18];
            2'd1: sextet = entry_reg.bits[17:12];
            2'd2: sextet = entry_reg.bits[11:6];
            2'd3: sextet = entry_reg.bits[5:0];
        endcase
    end

    always_comb
    begin
        unique case (entry_reg.pad)
            PAD_NONE: is_pad = 1'b0;
            PAD_ONE:  is_pad = final_pos;
            PAD_TWO:  is_pad = pos_reg[1];
            default:  is_pad = 1'b0;
        endcase
    end

    always_comb
    begin
        entry_next      = entry_reg;
        have_entry_next = have_entry_reg;
        pos_next        = pos_reg;
        out_valid_next  = out_valid_reg;
        out_char_next   = out_char_reg;
        out_last_next   = out_last_reg;
        if (out_valid_reg && char_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
            out_char_next  = is_pad ? PAD_CHAR : sextet_char(sextet);
            out_last_next  = entry_reg.last && final_pos;
            pos_next       = pos_reg + 2'd1;
            if (final_pos)
            begin
                have_entry_next = 1'b0;
            end
        end
        if (pop)
        begin
            entry_next      = pop_data;
            have_entry_next = 1'b1;
            pos_next        = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_entry_reg <= 1'b0;
            pos_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            have_entry_reg <= have_entry_next;
            pos_reg        <= pos_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg    <= entry_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign char_out.valid     = out_valid_reg;
    assign char_out.out_char  = out_char_reg;
    assign char_out.last_char = out_last_reg;

endmodule

// ----- rtl/base64_stream_encoder_core.sv -----
// ---------------------------------------------------------------------------
// base64_stream_encoder_core
// Streaming Base64-style encoder, alphabet a-z A-Z 0-9 + /, '=' padding.
// ---------------------------------------------------------------------------
// byte_in  : one message byte per word; end_of_message marks the final byte.
// char_out : one ASCII character per word; last_char marks the final one.
// A complete triple gives four characters; a final partial group gives two
// characters and "==" or three characters and "=".
// Input takes one byte per cycle while the group queue has room; output
// gives one character per cycle while the receiver is ready, so a steady
// stream is limited by the single-character output register.
// A completed group is registered into a queue slot, then into the entry
// register, and each of its characters then into the output register.
// A stalled receiver holds the output word; the queue of QUEUE_DEPTH groups
// keeps taking bytes until it fills, then byte_in.ready drops.
// Reset clears pending bytes, the queue and the output valid; byte_in.ready
// is high as soon as reset is released.
// ---------------------------------------------------------------------------
module base64_stream_encoder_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    b64e_byte_if.sink   byte_in,
    b64e_char_if.source char_out
);
    import b64e_pkg::*;

    group_t push_data;
    group_t pop_data;
    logic   push;
    logic   pop;
    logic   queue_full;
    logic   queue_empty;

    b64e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (queue_empty)
    );

    b64e_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .pop         (pop),
        .pop_data    (pop_data),
        .char_out    (char_out)
    );

endmodule

// ----- rtl/b64e_checker.sv -----
// ---------------------------------------------------------------------------
// b64e_checker
// Port-level checks on the encoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "base64_stream_encoder_core_assert.svh"

module b64e_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] out_char,
    input logic       last_char
);
    import b64e_pkg::*;

    logic out_stall;
    logic char_legal;
    logic pad_open;

    assign out_stall  = out_valid && !out_ready;
    assign char_legal = (out_char >= CHAR_LOWER_A && out_char <= CHAR_LOWER_Z)
                     || (out_char >= CHAR_UPPER_A && out_char <= CHAR_UPPER_Z)
                     || (out_char >= CHAR_DIGIT_0 && out_char <= CHAR_DIGIT_9)
                     || (out_char == CHAR_PLUS) || (out_char == CHAR_SLASH)
                     || (out_char == PAD_CHAR);
    assign pad_open   = out_valid && out_ready && (out_char == PAD_CHAR) && !last_char;

    `B64E_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable({out_char, last_char}))

    `B64E_ASSERT_IMPL(a_char_set, clk, rst_n, out_valid, char_legal)

    `B64E_ASSERT_NEXT(a_pad_pair, clk, rst_n, pad_open, out_valid && out_char == PAD_CHAR)

    `B64E_ASSERT_IMPL(a_full_busy, clk, rst_n, !in_ready, out_valid)

endmodule

bind base64_stream_encoder_core b64e_checker u_b64e_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (byte_in.ready),
    .out_valid (char_out.valid),
    .out_ready (char_out.ready),
    .out_char  (char_out.out_char),
    .last_char (char_out.last_char)
);

// ----- tb/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for base64_stream_encoder_core. Drives whole messages
// of bytes through the byte channel with bursty timing. Predicts the encoded
// characters and last_char flags for each accepted byte, and compares every
// character word that the receiver takes against the oldest prediction. The
// receiver changes its stall pattern over time, and holds off once for a long
// stretch so that the encoder fills and stalls its input.
// ---------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import b64e_pkg::*;

    localparam int RANDOM_BYTES   = 385;
    localparam int IDLE_LIMIT     = 3000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_AT_BYTE   = 60;
    localparam int HOLD_CYCLES    = 300;

    localparam bit [0:63][7:0] ALPHABET =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789+/";

    typedef struct packed {
        logic [7:0] data;
        logic       eom;
    } msg_byte_t;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } enc_char_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } rx_mode_t;

    logic clk;
    logic rst_n;

    b64e_byte_if byte_in ();
    b64e_char_if char_out ();

    base64_stream_encoder_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_in  (byte_in),
        .char_out (char_out)
    );

    msg_byte_t   msg_bytes_q[$];
    enc_char_t   encoded_chars[$];
    msg_byte_t   next_byte;
    enc_char_t   got_char;
    enc_char_t   want_char;

    logic [15:0] held_bytes;
    logic [1:0]  held_count;

    int          char_errors;
    int          bytes_taken;
    int          burst_left;
    int          gap_left;
    int          idle_cycles;
    int          hold_left;
    logic        hold_off;
    logic        hold_done;
    rx_mode_t    rx_mode;
    int          rx_left;
    logic [1:0]  rx_phase;
    logic        rx_go;

    function automatic logic [6:0] sextet_to_char(input logic [23:0] grp, input int shift);
        logic [5:0] idx;
        idx = 6'((grp >> shift) & 24'h3F);
        return ALPHABET[idx][6:0];
    endfunction

    task automatic push_char(input logic [6:0] ch, input logic last);
        enc_char_t c;
        c.ch = ch;
        c.last = last;
        encoded_chars.push_back(c);
    endtask

    task automatic encode_byte(input logic [7:0] b, input logic fin);
        logic [23:0] grp;
        if (held_count >= 2'd2)
        begin
            grp = {held_bytes, b};
            push_char(sextet_to_char(grp, 18), 1'b0);
            push_char(sextet_to_char(grp, 12), 1'b0);
            push_char(sextet_to_char(grp, 6), 1'b0);
            push_char(sextet_to_char(grp, 0), fin);
            held_bytes = '0;
            held_count = '0;
        end
        else if (!fin)
        begin
            if (held_count == 2'd0)
                held_bytes = {b, 8'h00};
            else
                held_bytes[7:0] = b;
            held_count = held_count + 2'd1;
        end
        else
        begin
            if (held_count == 2'd0)
            begin
                grp = {b, 16'h0000};
                push_char(sextet_to_char(grp, 18), 1'b0);
                push_char(sextet_to_char(grp, 12), 1'b0);
                push_char(PAD_CHAR, 1'b0);
                push_char(PAD_CHAR, 1'b1);
            end
            else
            begin
                grp = {held_bytes[15:8], b, 8'h00};
                push_char(sextet_to_char(grp, 18), 1'b0);
                push_char(sextet_to_char(grp, 12), 1'b0);
                push_char(sextet_to_char(grp, 6), 1'b0);
                push_char(PAD_CHAR, 1'b1);
            end
            held_bytes = '0;
            held_count = '0;
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        char_errors++;
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic eom);
        msg_byte_t m;
        m.data = b;
        m.eom = eom;
        msg_bytes_q.push_back(m);
    endtask

    function automatic logic [7:0] rand_byte();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return 8'h00;
        else if (pick == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        fork
            forever #5 clk = ~clk;
            begin
                repeat (6) @(posedge clk);
                rst_n <= 1'b1;
            end
        join_none
    end

    initial
    begin
        int total;
        int len;
        held_bytes = '0;
        held_count = '0;
        char_errors = 0;

        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'hFB, 1'b0);
        queue_byte(8'hEF, 1'b0);
        queue_byte(8'hBE, 1'b1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h10, 1'b0);
        queue_byte(8'h83, 1'b0);
        queue_byte(8'h10, 1'b0);
        queue_byte(8'h51, 1'b0);
        queue_byte(8'h87, 1'b1);
        queue_byte(8'h12, 1'b0);
        queue_byte(8'h34, 1'b0);
        queue_byte(8'h56, 1'b0);
        queue_byte(8'h78, 1'b1);
        queue_byte(8'hAB, 1'b0);
        queue_byte(8'hCD, 1'b0);
        queue_byte(8'hEF, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h23, 1'b1);

        total = 0;
        while (total < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(13, 40);
            else
                len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
                queue_byte(rand_byte(), i == len - 1);
            total += len;
        end

        wait (rst_n === 1'b1);
        while (msg_bytes_q.size() != 0 || byte_in.valid || encoded_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (char_errors == 0)
            $display("PASS base64_stream_encoder_core");
        else
            $display("FAIL base64_stream_encoder_core");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_in.valid <= 1'b0;
            byte_in.data_byte <= 8'h00;
            byte_in.end_of_message <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (!byte_in.valid || byte_in.ready)
        begin
            if (gap_left != 0 || msg_bytes_q.size() == 0)
            begin
                byte_in.valid <= 1'b0;
                if (gap_left != 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                next_byte = msg_bytes_q.pop_front();
                byte_in.valid <= 1'b1;
                byte_in.data_byte <= next_byte.data;
                byte_in.end_of_message <= next_byte.eom;
                if (burst_left <= 1)
                begin
                    if ($urandom_range(0, 5) == 0)
                    begin
                        burst_left <= 40;
                        gap_left <= 0;
                    end
                    else
                    begin
                        burst_left <= $urandom_range(1, 16);
                        if ($urandom_range(0, 7) == 0)
                            gap_left <= $urandom_range(8, 20);
                        else
                            gap_left <= $urandom_range(0, 4);
                    end
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_out.ready <= 1'b0;
            rx_mode <= RX_OPEN;
            rx_left <= 0;
            rx_phase <= '0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode <= rx_mode_t'($urandom_range(0, 3));
                rx_left <= $urandom_range(20, 80);
            end
            else
            begin
                rx_left <= rx_left - 1;
            end
            rx_phase <= rx_phase + 2'd1;
            unique case (rx_mode)
                RX_OPEN:   rx_go = 1'b1;
                RX_COIN:   rx_go = 1'($urandom_range(0, 1));
                RX_SPARSE: rx_go = (rx_phase == 2'd0);
                default:   rx_go = ($urandom_range(0, 7) != 0);
            endcase
            char_out.ready <= rx_go && !hold_off;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && bytes_taken >= HOLD_AT_BYTE)
        begin
            hold_off <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            if (hold_left == 1)
                hold_off <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_taken <= 0;
        end
        else
        begin
            if (byte_in.valid && byte_in.ready)
            begin
                encode_byte(byte_in.data_byte, byte_in.end_of_message);
                bytes_taken <= bytes_taken + 1;
            end
            if (char_out.valid && char_out.ready)
            begin
                got_char.ch = char_out.out_char;
                got_char.last = char_out.last_char;
                if (encoded_chars.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected char 0x%02h last=%0b",
                                              got_char.ch, got_char.last));
                end
                else
                begin
                    want_char = encoded_chars.pop_front();
                    if (got_char.ch !== want_char.ch)
                        report_mismatch($sformatf("out_char 0x%02h, want 0x%02h",
                                                  got_char.ch, want_char.ch));
                    if (got_char.last !== want_char.last)
                        report_mismatch($sformatf("last_char %0b, want %0b (char 0x%02h)",
                                                  got_char.last, want_char.last,
                                                  want_char.ch));
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else if ((byte_in.valid && byte_in.ready) || (char_out.valid && char_out.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TIMEOUT @%0t: no word moved for %0d cycles", $realtime, IDLE_LIMIT);
            $display("FAIL base64_stream_encoder_core");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
